### rtl/hsv2rgb_pkg.sv
// Shared types, widths and constants of the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam int unsigned CHANNEL_BITS = 8;
	localparam int unsigned HUE_BITS     = 9;
	localparam int unsigned CMAX         = (1 << CHANNEL_BITS) - 1;
	localparam int unsigned HUE_FULL     = 360;
	localparam int unsigned SECTOR_DEG   = 60;

	// Common denominator of every channel: one full sector times full scale.
	localparam int unsigned DIV     = SECTOR_DEG * CMAX;
	localparam int unsigned DEF_W   = $clog2(SECTOR_DEG + 1);
	localparam int unsigned TERM_W  = CHANNEL_BITS + DEF_W;
	localparam int unsigned INNER_W = $clog2(DIV + 1);
	localparam int unsigned NUM_W   = CHANNEL_BITS + INNER_W;

	// floor(2^NUM_W / DIV): the estimate it gives is short by at most one.
	localparam longint unsigned RECIP = (64'd1 << NUM_W) / DIV;
	localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
	localparam int unsigned PROD_W    = NUM_W + RECIP_W;

	// Pipeline depth from input register to output register.
	localparam int unsigned DEPTH = 5;

	typedef logic [CHANNEL_BITS-1:0]   chan_t;
	typedef logic [HUE_BITS-1:0]       hue_t;
	typedef logic [DEF_W-1:0]          deficit_t;
	typedef logic [TERM_W-1:0]         term_t;
	typedef logic [INNER_W-1:0]        inner_t;
	typedef logic [NUM_W-1:0]          num_t;
	typedef logic [RECIP_W-1:0]        recip_t;
	typedef logic [PROD_W-1:0]         prod_t;
	typedef logic [3*CHANNEL_BITS-1:0] packed_t;

	// Six 60-degree hue sectors, named by the colors at their ends.
	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

endpackage

### rtl/hsv2rgb_if.sv
// Valid/ready channel interfaces for HSV items in and RGB items out.
interface hsv2rgb_hsv_if;
	logic                 valid;
	logic                 ready;
	hsv2rgb_pkg::hue_t    hue;
	hsv2rgb_pkg::chan_t   saturation;
	hsv2rgb_pkg::chan_t   brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
	logic                 valid;
	logic                 ready;
	hsv2rgb_pkg::chan_t   red;
	hsv2rgb_pkg::chan_t   green;
	hsv2rgb_pkg::chan_t   blue;
	hsv2rgb_pkg::packed_t packed_color;

	modport source (output valid, red, green, blue, packed_color, input ready);
	modport sink   (input valid, red, green, blue, packed_color, output ready);
endinterface

### rtl/hsv_to_rgb_top.sv
// HSV to RGB converter: five-stage pipeline from hue, saturation, value to a pixel.
//
// Channels: hsv takes one color item (hue in degrees, saturation and
// brightness as fractions of full scale), rgb delivers one pixel item
// (red, green, blue and the packed word with red in the high byte).
// Both use valid/ready; an item moves at a clock edge with both high.
// Hue values of 360 and above wrap by 360.
//
// Throughput is one item per cycle while the receiver keeps rgb.ready high;
// the stage that divides by 60 * full scale with a reciprocal multiply and
// a one-step correction sets the depth.
//
// Each stage holds its own valid bit and moves whenever the stage after it
// is empty or moving, so bubbles close up. When the receiver stalls, the
// output register holds its item and up to four more items are still taken
// before hsv.ready falls. Reset empties the pipeline; no item is lost or
// repeated across a stall.
module hsv_to_rgb_top (
	input  logic                 clk,
	input  logic                 arst_n,
	hsv2rgb_hsv_if.sink          hsv,
	hsv2rgb_rgb_if.source        rgb
);

	// Stage valid bits and per-stage advance enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	assign adv_s5 = !valid_s5 || rgb.ready;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign hsv.ready = adv_s1;

	// Stage 1 logic: sector decode and per-channel weight deficit (60 - w).
	hsv2rgb_pkg::hue_t     hue_wrap;
	hsv2rgb_pkg::sector_t  sector;
	hsv2rgb_pkg::hue_t     sector_base;
	hsv2rgb_pkg::deficit_t frac;
	hsv2rgb_pkg::deficit_t def_mid;
	hsv2rgb_pkg::deficit_t def_full;
	hsv2rgb_pkg::deficit_t def_in [3];

	always_comb begin
		hue_wrap = (hsv.hue >= hsv2rgb_pkg::hue_t'(hsv2rgb_pkg::HUE_FULL))
			? hsv.hue - hsv2rgb_pkg::hue_t'(hsv2rgb_pkg::HUE_FULL) : hsv.hue;
		if (hue_wrap >= hsv2rgb_pkg::hue_t'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
			sector = hsv2rgb_pkg::SEC_MAGENTA_RED;
		end else if (hue_wrap >= hsv2rgb_pkg::hue_t'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
			sector = hsv2rgb_pkg::SEC_BLUE_MAGENTA;
		end else if (hue_wrap >= hsv2rgb_pkg::hue_t'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
			sector = hsv2rgb_pkg::SEC_CYAN_BLUE;
		end else if (hue_wrap >= hsv2rgb_pkg::hue_t'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
			sector = hsv2rgb_pkg::SEC_GREEN_CYAN;
		end else if (hue_wrap >= hsv2rgb_pkg::hue_t'(hsv2rgb_pkg::SECTOR_DEG)) begin
			sector = hsv2rgb_pkg::SEC_YELLOW_GREEN;
		end else begin
			sector = hsv2rgb_pkg::SEC_RED_YELLOW;
		end
	end

	always_comb begin
		sector_base = hsv2rgb_pkg::hue_t'(sector) *
			hsv2rgb_pkg::hue_t'(hsv2rgb_pkg::SECTOR_DEG);
		frac = hsv2rgb_pkg::deficit_t'(hue_wrap - sector_base);
		def_full = hsv2rgb_pkg::deficit_t'(hsv2rgb_pkg::SECTOR_DEG);
		// The middle channel rises through even sectors and falls through odd ones.
		def_mid = sector[0] ? frac : def_full - frac;
		case (sector)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				def_in[0] = '0;       def_in[1] = def_mid;  def_in[2] = def_full;
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				def_in[0] = def_mid;  def_in[1] = '0;       def_in[2] = def_full;
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				def_in[0] = def_full; def_in[1] = '0;       def_in[2] = def_mid;
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				def_in[0] = def_full; def_in[1] = def_mid;  def_in[2] = '0;
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				def_in[0] = def_mid;  def_in[1] = def_full; def_in[2] = '0;
			end
			default: begin
				def_in[0] = '0;       def_in[1] = def_full; def_in[2] = def_mid;
			end
		endcase
	end

	hsv2rgb_pkg::chan_t    sat_s1, val_s1;
	hsv2rgb_pkg::deficit_t def_s1 [3];

	// Stage 2 logic: inner = 60*CMAX - S*deficit, equal to S*w + 60*(CMAX - S).
	hsv2rgb_pkg::chan_t    val_s2;
	hsv2rgb_pkg::inner_t   inner_s2 [3];
	hsv2rgb_pkg::inner_t   inner_d  [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			inner_d[c] = hsv2rgb_pkg::inner_t'(hsv2rgb_pkg::DIV) -
				hsv2rgb_pkg::inner_t'(hsv2rgb_pkg::term_t'(sat_s1) *
				hsv2rgb_pkg::term_t'(def_s1[c]));
		end
	end

	// Stage 3 logic: numerator V * inner.
	hsv2rgb_pkg::num_t num_s3 [3];
	hsv2rgb_pkg::num_t num_d  [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_d[c] = hsv2rgb_pkg::num_t'(val_s2) * hsv2rgb_pkg::num_t'(inner_s2[c]);
		end
	end

	// Stage 4 logic: quotient estimate by reciprocal multiply.
	hsv2rgb_pkg::num_t  num_s4  [3];
	hsv2rgb_pkg::chan_t qest_s4 [3];
	hsv2rgb_pkg::chan_t qest_d  [3];
	hsv2rgb_pkg::prod_t qprod   [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qprod[c] = hsv2rgb_pkg::prod_t'(num_s3[c]) *
				hsv2rgb_pkg::prod_t'(hsv2rgb_pkg::recip_t'(hsv2rgb_pkg::RECIP));
			qest_d[c] = hsv2rgb_pkg::chan_t'(qprod[c] >> hsv2rgb_pkg::NUM_W);
		end
	end

	// Stage 5 logic: the estimate is exact or one short; the remainder decides.
	hsv2rgb_pkg::chan_t chan_s5 [3];
	hsv2rgb_pkg::chan_t chan_d  [3];
	hsv2rgb_pkg::num_t  rem     [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rem[c] = num_s4[c] - hsv2rgb_pkg::num_t'(qest_s4[c]) *
				hsv2rgb_pkg::num_t'(hsv2rgb_pkg::DIV);
			chan_d[c] = (rem[c] >= hsv2rgb_pkg::num_t'(hsv2rgb_pkg::DIV))
				? qest_s4[c] + 1'b1 : qest_s4[c];
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= hsv.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sat_s1 <= hsv.saturation;
			val_s1 <= hsv.brightness;
			def_s1 <= def_in;
		end
		if (adv_s2) begin
			val_s2   <= val_s1;
			inner_s2 <= inner_d;
		end
		if (adv_s3) begin
			num_s3 <= num_d;
		end
		if (adv_s4) begin
			num_s4  <= num_s3;
			qest_s4 <= qest_d;
		end
		if (adv_s5) begin
			chan_s5 <= chan_d;
		end
	end

	assign rgb.valid        = valid_s5;
	assign rgb.red          = chan_s5[0];
	assign rgb.green        = chan_s5[1];
	assign rgb.blue         = chan_s5[2];
	assign rgb.packed_color = {chan_s5[0], chan_s5[1], chan_s5[2]};

endmodule

### rtl/hsv2rgb_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
module hsv2rgb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input hsv2rgb_pkg::chan_t   red,
	input hsv2rgb_pkg::chan_t   green,
	input hsv2rgb_pkg::chan_t   blue,
	input hsv2rgb_pkg::packed_t packed_color
);

	localparam int unsigned CNT_W = $clog2(hsv2rgb_pkg::DEPTH + 2);

	logic             in_take, out_take;
	logic [CNT_W-1:0] inflight_q;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_take && !out_take) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_take && !in_take) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// A result item shows only when some accepted item is still owed.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result item without an accepted input item");

	// The pipeline never holds more items than it has stages.
	assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(hsv2rgb_pkg::DEPTH))
		else $error("more items in flight than pipeline stages");

	// The packed word of a valid result item agrees with the three channels.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> packed_color == {red, green, blue})
		else $error("packed word does not match channels");

	// A stalled result item stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_color))
		else $error("stalled result item changed or dropped");

endmodule

bind hsv_to_rgb_top hsv2rgb_checker u_hsv2rgb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (hsv.valid),
	.in_ready     (hsv.ready),
	.out_valid    (rgb.valid),
	.out_ready    (rgb.ready),
	.red          (rgb.red),
	.green        (rgb.green),
	.blue         (rgb.blue),
	.packed_color (rgb.packed_color)
);

### dv/hsv_to_rgb_top_tb.sv
// Self-checking testbench for the HSV to RGB converter pipeline.
`timescale 1ns / 100ps

module hsv_to_rgb_top_tb;

	localparam int unsigned IDLE_LIMIT    = 2000;
	localparam int unsigned RANDOM_BATCH  = 157;
	localparam int unsigned RANDOM_BATCHES = 4;
	localparam int unsigned MAX_REPORTS   = 40;

	typedef struct packed {
		hsv2rgb_pkg::hue_t  hue;
		hsv2rgb_pkg::chan_t saturation;
		hsv2rgb_pkg::chan_t brightness;
	} color_t;

	typedef struct packed {
		hsv2rgb_pkg::chan_t   red;
		hsv2rgb_pkg::chan_t   green;
		hsv2rgb_pkg::chan_t   blue;
		hsv2rgb_pkg::packed_t packed_color;
	} pixel_t;

	logic clk;
	logic arst_n;

	hsv2rgb_hsv_if hsv_ch ();
	hsv2rgb_rgb_if rgb_ch ();

	hsv_to_rgb_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	color_t      color_queue[$];
	pixel_t      pixel_queue[$];
	color_t      next_color;
	logic        hsv_took;
	logic        calm;
	int unsigned tx_gap;
	int unsigned rx_stall;
	int unsigned idle_cycles;
	int unsigned error_count;
	int unsigned colors_in;
	int unsigned pixels_checked;
	int unsigned wrapped_count;
	int unsigned grey_count;

	// One channel: floor(V * (S*w + 60*(CMAX - S)) / (60*CMAX)), w being the sector weight.
	function automatic hsv2rgb_pkg::chan_t chan_level(int unsigned s, int unsigned v,
		int unsigned w);
		longint unsigned num;
		num = longint'(v) * longint'(s * w + hsv2rgb_pkg::SECTOR_DEG *
			(hsv2rgb_pkg::CMAX - s));
		return hsv2rgb_pkg::chan_t'(num / (hsv2rgb_pkg::SECTOR_DEG * hsv2rgb_pkg::CMAX));
	endfunction

	function automatic pixel_t calc_pixel(color_t c);
		int unsigned          h;
		int unsigned          f;
		int unsigned          mid;
		int unsigned          wr;
		int unsigned          wg;
		int unsigned          wb;
		hsv2rgb_pkg::sector_t sec;
		pixel_t               p;
		h = c.hue;
		if (h >= hsv2rgb_pkg::HUE_FULL) begin
			h = h - hsv2rgb_pkg::HUE_FULL;
		end
		sec = hsv2rgb_pkg::sector_t'(h / hsv2rgb_pkg::SECTOR_DEG);
		f   = h % hsv2rgb_pkg::SECTOR_DEG;
		mid = sec[0] ? hsv2rgb_pkg::SECTOR_DEG - f : f;
		case (sec)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				wr = hsv2rgb_pkg::SECTOR_DEG; wg = mid; wb = 0;
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				wr = mid; wg = hsv2rgb_pkg::SECTOR_DEG; wb = 0;
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				wr = 0; wg = hsv2rgb_pkg::SECTOR_DEG; wb = mid;
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				wr = 0; wg = mid; wb = hsv2rgb_pkg::SECTOR_DEG;
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				wr = mid; wg = 0; wb = hsv2rgb_pkg::SECTOR_DEG;
			end
			default: begin
				wr = hsv2rgb_pkg::SECTOR_DEG; wg = 0; wb = mid;
			end
		endcase
		p.red          = chan_level(c.saturation, c.brightness, wr);
		p.green        = chan_level(c.saturation, c.brightness, wg);
		p.blue         = chan_level(c.saturation, c.brightness, wb);
		p.packed_color = {p.red, p.green, p.blue};
		return p;
	endfunction

	// Saturation and brightness lean toward the ends and the middle of their range now and then.
	function automatic hsv2rgb_pkg::chan_t pick_level();
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 4))
				0: return hsv2rgb_pkg::chan_t'(0);
				1: return hsv2rgb_pkg::chan_t'(1);
				2: return hsv2rgb_pkg::chan_t'(128);
				3: return hsv2rgb_pkg::chan_t'(hsv2rgb_pkg::CMAX - 1);
				default: return hsv2rgb_pkg::chan_t'(hsv2rgb_pkg::CMAX);
			endcase
		end
		return hsv2rgb_pkg::chan_t'($urandom_range(0, hsv2rgb_pkg::CMAX));
	endfunction

	function automatic hsv2rgb_pkg::hue_t pick_hue();
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 2))
					0: return hsv2rgb_pkg::hue_t'($urandom_range(0, 5) *
						hsv2rgb_pkg::SECTOR_DEG);
					1: return hsv2rgb_pkg::hue_t'($urandom_range(0, 5) *
						hsv2rgb_pkg::SECTOR_DEG + 1);
					default: return hsv2rgb_pkg::hue_t'($urandom_range(0, 5) *
						hsv2rgb_pkg::SECTOR_DEG + hsv2rgb_pkg::SECTOR_DEG - 1);
				endcase
			end
			2: return hsv2rgb_pkg::hue_t'($urandom_range(hsv2rgb_pkg::HUE_FULL,
				(1 << hsv2rgb_pkg::HUE_BITS) - 1));
			default: return hsv2rgb_pkg::hue_t'($urandom_range(0, hsv2rgb_pkg::HUE_FULL - 1));
		endcase
	endfunction

	task automatic add_color(int unsigned h, int unsigned s, int unsigned v);
		color_t c;
		c.hue        = hsv2rgb_pkg::hue_t'(h);
		c.saturation = hsv2rgb_pkg::chan_t'(s);
		c.brightness = hsv2rgb_pkg::chan_t'(v);
		color_queue.push_back(c);
	endtask

	// Hold off new colors until every queued one has come back as a pixel.
	// The sender's valid is steady at the rising edge, so the test is made there.
	task automatic drain();
		while (color_queue.size() != 0 || hsv_ch.valid || pixel_queue.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			error_count++;
			if (error_count <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#2 clk = ~clk;
		end
	end

	initial begin
		arst_n           = 1'b0;
		hsv_ch.valid      = 1'b0;
		hsv_ch.hue        = '0;
		hsv_ch.saturation = '0;
		hsv_ch.brightness = '0;
		rgb_ch.ready      = 1'b0;
		hsv_took         = 1'b0;
		calm             = 1'b0;
		tx_gap           = 0;
		rx_stall         = 0;
		idle_cycles      = 0;
		error_count      = 0;
		colors_in        = 0;
		pixels_checked   = 0;
		wrapped_count    = 0;
		grey_count       = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Primaries, secondaries, sector edges, hue wrap, grey and black.
		add_color(0, 255, 255);
		add_color(60, 255, 255);
		add_color(120, 255, 255);
		add_color(180, 255, 255);
		add_color(240, 255, 255);
		add_color(300, 255, 255);
		add_color(359, 255, 255);
		add_color(59, 255, 255);
		add_color(61, 255, 200);
		add_color(119, 200, 255);
		add_color(0, 0, 0);
		add_color(511, 255, 255);
		add_color(360, 255, 255);
		add_color(419, 128, 77);
		add_color(256, 170, 85);
		add_color(200, 0, 200);
		add_color(45, 255, 0);
		add_color(30, 1, 255);
		add_color(90, 254, 1);
		add_color(150, 170, 85);
		add_color(270, 85, 170);
		add_color(330, 0, 255);
		drain();

		for (int b = 0; b < RANDOM_BATCHES; b++) begin
			if (b == RANDOM_BATCHES - 1) begin
				calm = 1'b1;
			end
			for (int i = 0; i < RANDOM_BATCH; i++) begin
				add_color(pick_hue(), pick_level(), pick_level());
			end
			drain();
		end

		repeat (hsv2rgb_pkg::DEPTH + 4) @(posedge clk);
		$display("Converted %0d colors, %0d with wrapped hue and %0d grey; %0d pixels compared.",
			colors_in, wrapped_count, grey_count, pixels_checked);
		$display("Sender gaps and receiver stalls were mixed in, with a quiet final stretch.");
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Driver: a presented item stays on the bus until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hsv_ch.valid && !hsv_took) begin
				// Still waiting for the sink.
			end else if (tx_gap > 0) begin
				hsv_ch.valid <= 1'b0;
				tx_gap       <= tx_gap - 1;
			end else if (color_queue.size() != 0) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					hsv_ch.valid <= 1'b0;
					tx_gap       <= $urandom_range(0, 14);
				end else begin
					next_color        = color_queue.pop_front();
					hsv_ch.valid      <= 1'b1;
					hsv_ch.hue        <= next_color.hue;
					hsv_ch.saturation <= next_color.saturation;
					hsv_ch.brightness <= next_color.brightness;
				end
			end else begin
				hsv_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_stall > 0) begin
				rgb_ch.ready <= 1'b0;
				rx_stall     <= rx_stall - 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rgb_ch.ready <= 1'b0;
				rx_stall     <= $urandom_range(0, 14);
			end else begin
				rgb_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: pixels are checked before the color taken at the same edge is predicted.
	always @(posedge clk) begin
		color_t c;
		pixel_t want;
		hsv_took <= hsv_ch.valid && hsv_ch.ready;
		if (arst_n) begin
			if (rgb_ch.valid && rgb_ch.ready) begin
				if (pixel_queue.size() == 0) begin
					error_count++;
					$display("%0t: pixel 0x%0h arrived with nothing expected",
						$time, rgb_ch.packed_color);
				end else begin
					want = pixel_queue.pop_front();
					check_field("red", want.red, rgb_ch.red);
					check_field("green", want.green, rgb_ch.green);
					check_field("blue", want.blue, rgb_ch.blue);
					check_field("packed_color", want.packed_color, rgb_ch.packed_color);
					pixels_checked++;
				end
			end
			if (hsv_ch.valid && hsv_ch.ready) begin
				c.hue        = hsv_ch.hue;
				c.saturation = hsv_ch.saturation;
				c.brightness = hsv_ch.brightness;
				pixel_queue.push_back(calc_pixel(c));
				colors_in++;
				if (c.hue >= hsv2rgb_pkg::HUE_FULL) begin
					wrapped_count++;
				end
				if (c.saturation == 0) begin
					grey_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d pixels still expected",
					$time, IDLE_LIMIT, pixel_queue.size());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
